/* rtl/esd_pkg.sv */
// Package for the escape sequence decoder: beat types, the result group
// passed from the decoder to the result queue, and character codes.
// No dependencies.
package esd_pkg;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_mark;
  } esd_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       is_end;
    logic       last_of_run;
  } esd_out_t;

  typedef struct packed {
    logic [1:0] count;
    esd_out_t   first;
    esd_out_t   second;
  } esd_res_t;

  typedef enum logic [4:0] {
    ModeNormal = 5'b00001,
    ModeEsc    = 5'b00010,
    ModePos    = 5'b00100,
    ModeNeg    = 5'b01000,
    ModeZero   = 5'b10000
  } esd_mode_e;

  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharHash      = 8'h23;
  localparam logic [7:0] CharAt        = 8'h40;
  localparam logic [7:0] CharN         = 8'h6E;
  localparam logic [7:0] CharT         = 8'h74;
  localparam logic [7:0] CharPct       = 8'h25;
  localparam logic [7:0] CharQuote     = 8'h22;
  localparam logic [7:0] CharApos      = 8'h27;
  localparam logic [7:0] CharLf        = 8'h0A;
  localparam logic [7:0] CharTab       = 8'h09;
  localparam logic [7:0] CharCr        = 8'h0D;
  localparam logic [7:0] CharSpace     = 8'h20;
  localparam logic [7:0] CharPlus      = 8'h2B;
  localparam logic [7:0] CharMinus     = 8'h2D;
  localparam logic [7:0] CharZero      = 8'h30;
  localparam logic [7:0] CharNine      = 8'h39;

endpackage

/* rtl/escape_sequence_decoder.sv */
// Escape sequence decoder, top level: joins the decoder core and the
// result queue. Depends on esd_pkg, esd_decode and esd_queue.
//
// One string byte or end mark is taken per cycle and decoded in the same
// cycle into at most two results, which enter a three-entry result queue;
// results leave one per cycle while out_stall_i is low, so plain text, one
// result per byte, streams at one beat per cycle. A beat that gives two
// results (a decimal field closed by a byte other than a backslash, or an end
// mark after a pending escape or decimal field) outpaces the single output
// port, and the input stalls while more than one result waits in the queue.
module escape_sequence_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  esd_pkg::esd_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output esd_pkg::esd_out_t out_data_o
);

  logic              accept;
  logic              full;
  esd_pkg::esd_res_t res;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  esd_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_data_i(in_data_i),
    .res_o    (res)
  );

  esd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .res_i      (res),
    .full_o     (full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.end_mark |=> out_valid_o)
    else $error("end mark accepted without a result");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_end |-> out_data_o.last_of_run)
    else $error("closing result not marked last");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last_of_run |=> out_valid_o)
    else $error("second result of a run missing");

endmodule

/* rtl/esd_decode.sv */
// Escape decoder core: mode and decimal accumulator registers, and the
// logic that turns one input beat into up to two results.
// Depends on esd_pkg.
module esd_decode (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  esd_pkg::esd_in_t in_data_i,
  output esd_pkg::esd_res_t res_o
);

  esd_pkg::esd_mode_e mode_q, mode_d;
  logic [7:0]         acc_q, acc_d;

  logic [7:0] c;
  logic       is_digit;
  logic       is_space;
  logic [7:0] digit_val;
  logic [7:0] field_val;
  logic [7:0] mapped;
  logic       is_mapped;
  logic       decimal;

  assign c         = in_data_i.in_char;
  assign is_digit  = c inside {[esd_pkg::CharZero:esd_pkg::CharNine]};
  assign is_space  = (c == esd_pkg::CharSpace) || (c inside {[esd_pkg::CharTab:esd_pkg::CharCr]});
  assign digit_val = c - esd_pkg::CharZero;
  assign decimal   = (mode_q == esd_pkg::ModePos) || (mode_q == esd_pkg::ModeNeg) ||
                     (mode_q == esd_pkg::ModeZero);

  always_comb begin
    case (mode_q)
      esd_pkg::ModeNeg:  field_val = 8'd0 - acc_q;
      esd_pkg::ModeZero: field_val = 8'd0;
      default:           field_val = acc_q;
    endcase
  end

  always_comb begin
    is_mapped = 1'b1;
    case (c)
      esd_pkg::CharN:         mapped = esd_pkg::CharLf;
      esd_pkg::CharT:         mapped = esd_pkg::CharTab;
      esd_pkg::CharPct:       mapped = esd_pkg::CharPct;
      esd_pkg::CharHash:      mapped = esd_pkg::CharAt;
      esd_pkg::CharQuote:     mapped = esd_pkg::CharQuote;
      esd_pkg::CharApos:      mapped = esd_pkg::CharApos;
      esd_pkg::CharBackslash: mapped = esd_pkg::CharBackslash;
      default: begin
        mapped    = 8'd0;
        is_mapped = 1'b0;
      end
    endcase
  end

  always_comb begin
    esd_pkg::esd_res_t r;
    r        = '0;
    mode_d   = mode_q;
    acc_d    = acc_q;
    if (in_data_i.end_mark) begin
      if (mode_q == esd_pkg::ModeEsc) begin
        r.first.out_char = 8'd0;
        r.second.is_end  = 1'b1;
        r.count          = 2'd2;
      end else if (decimal) begin
        r.first.out_char = field_val;
        r.second.is_end  = 1'b1;
        r.count          = 2'd2;
      end else begin
        r.first.is_end = 1'b1;
        r.count        = 2'd1;
      end
      mode_d = esd_pkg::ModeNormal;
      acc_d  = 8'd0;
    end else if (mode_q == esd_pkg::ModeEsc) begin
      if (is_mapped) begin
        r.first.out_char = mapped;
        r.count          = 2'd1;
        mode_d           = esd_pkg::ModeNormal;
      end else if (is_digit) begin
        acc_d  = digit_val;
        mode_d = esd_pkg::ModePos;
      end else if ((c == esd_pkg::CharPlus) || is_space) begin
        acc_d  = 8'd0;
        mode_d = esd_pkg::ModePos;
      end else if (c == esd_pkg::CharMinus) begin
        acc_d  = 8'd0;
        mode_d = esd_pkg::ModeNeg;
      end else begin
        acc_d  = 8'd0;
        mode_d = esd_pkg::ModeZero;
      end
    end else if (decimal) begin
      if (is_digit) begin
        if (mode_q != esd_pkg::ModeZero) begin
          acc_d = (acc_q << 3) + (acc_q << 1) + digit_val;
        end
      end else begin
        r.first.out_char = field_val;
        acc_d            = 8'd0;
        if (c == esd_pkg::CharBackslash) begin
          r.count = 2'd1;
          mode_d  = esd_pkg::ModeEsc;
        end else begin
          r.second.out_char = c;
          r.count           = 2'd2;
          mode_d            = esd_pkg::ModeNormal;
        end
      end
    end else begin
      if (c == esd_pkg::CharBackslash) begin
        mode_d = esd_pkg::ModeEsc;
      end else begin
        r.first.out_char = c;
        r.count          = 2'd1;
        mode_d           = esd_pkg::ModeNormal;
      end
    end
    r.first.last_of_run  = (r.count == 2'd1);
    r.second.last_of_run = (r.count == 2'd2);
    res_o = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= esd_pkg::ModeNormal;
      acc_q  <= 8'd0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
    end
  end

endmodule

/* rtl/esd_queue.sv */
// Three-entry result queue: takes up to two results per input beat and
// hands out one result beat per cycle while out_stall_i is low. Depends on esd_pkg.
module esd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  esd_pkg::esd_res_t res_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output esd_pkg::esd_out_t out_data_o
);

  esd_pkg::esd_out_t slot_q [3];
  esd_pkg::esd_out_t slot_d [3];
  logic [1:0]        count_q, count_d;
  logic              pop;
  logic [1:0]        cnt;

  assign pop         = (count_q != 2'd0) && !out_stall_i;
  assign full_o      = (count_q > 2'd1);
  assign out_valid_o = (count_q != 2'd0);
  assign out_data_o  = slot_q[0];

  always_comb begin
    cnt       = count_q - {1'b0, pop};
    slot_d[0] = pop ? slot_q[1] : slot_q[0];
    slot_d[1] = pop ? slot_q[2] : slot_q[1];
    slot_d[2] = slot_q[2];
    count_d   = cnt;
    if (push_i) begin
      if (res_i.count != 2'd0) begin
        slot_d[cnt] = res_i.first;
      end
      if (res_i.count == 2'd2) begin
        slot_d[cnt + 2'd1] = res_i.second;
      end
      count_d = cnt + res_i.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule
